// File: hw/rtl/acss_pkg.sv
// ----------------------------------------------------------------------------
// ADC scan sequencer package
// Shared widths, request and register codes, and the gain bias table.
// ----------------------------------------------------------------------------
package acss_pkg;

	// Field widths
	localparam int MAP_W    = 16;
	localparam int OFFSET_W = 12;
	localparam int GAIN_W   = 3;
	localparam int SAMPLE_W = 12;
	localparam int SLOT_W   = 4;
	localparam int CHAN_W   = 4;
	localparam int RAW_W    = 16;
	localparam int MV_W     = 33;
	localparam int LEN_W    = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// Parameter defaults
	localparam int NUM_CHANNELS_DEF = 16;
	localparam int SAMPLE_BITS_DEF  = 12;

	// Request codes
	typedef enum logic [1:0] {
		REQ_CONV_DONE = 2'd0,
		REQ_START     = 2'd1,
		REQ_STOP      = 2'd2,
		REQ_READ      = 2'd3
	} req_type_t;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MAP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CAL_OFFSET  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PGA_GAIN    = 2'd2;

	// Gain codes
	localparam logic [GAIN_W-1:0] GAIN_RESET = 3'd2;
	localparam logic [GAIN_W-1:0] GAIN_OFF   = 3'd7;
	localparam logic [GAIN_W-1:0] GAIN_MAX_SHIFT = 3'd6;

	// Millivolt scale per LSB before the gain shift
	localparam logic signed [11:0] MV_PER_LSB = 12'sd1050;

	// Bias added after scaling, per gain code (Q15 millivolts)
	function automatic logic signed [MV_W-1:0] gain_bias(input logic [GAIN_W-1:0] g);
		logic signed [MV_W-1:0] b;
		begin
			case (g)
				3'd0: b = -33'sd103219200;
				3'd1: b = -33'sd34406400;
				3'd2: b = 33'sd0;
				3'd3: b = 33'sd17203200;
				3'd4: b = 33'sd25804800;
				3'd5: b = 33'sd30105600;
				3'd6: b = 33'sd32256000;
				default: b = 33'sd0;
			endcase
			return b;
		end
	endfunction

	// Population count of a channel map
	function automatic logic [LEN_W-1:0] pop_map(input logic [MAP_W-1:0] m);
		logic [LEN_W-1:0] n;
		begin
			n = '0;
			for (int i = 0; i < MAP_W; i++) begin
				n = n + LEN_W'(m[i]);
			end
			return n;
		end
	endfunction

endpackage

// File: hw/rtl/acss_if.sv
// ----------------------------------------------------------------------------
// ADC scan sequencer channels
// Request and response valid/ready channels with their payloads.
// ----------------------------------------------------------------------------
interface acss_req_if;
	import acss_pkg::*;

	logic                valid;
	logic                ready;
	req_type_t           req_type;
	logic [SAMPLE_W-1:0] sample;
	logic [SLOT_W-1:0]   read_slot;

	modport source (output valid, req_type, sample, read_slot, input ready);
	modport sink   (input valid, req_type, sample, read_slot, output ready);
endinterface

interface acss_rsp_if;
	import acss_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   start_conversion;
	logic [CHAN_W-1:0]      next_channel;
	logic                   scan_empty;
	logic signed [RAW_W-1:0] raw_value;
	logic signed [MV_W-1:0] millivolts_q15;

	modport source (output valid, start_conversion, next_channel, scan_empty, raw_value,
		millivolts_q15, input ready);
	modport sink   (input valid, start_conversion, next_channel, scan_empty, raw_value,
		millivolts_q15, output ready);
endinterface

// File: hw/rtl/adc_channel_scan_sequencer.sv
// ----------------------------------------------------------------------------
// ADC channel scan sequencer
// Round-robin scan controller for a SAR converter with calibrated readout.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request per handshake: conversion done (with its sample),
//   start scan, stop scan, or read of a stored slot. rsp returns exactly one
//   response per request: the next channel to convert when a conversion should
//   begin, the empty-map flag, and for reads the offset-corrected value and
//   its Q15 millivolt equivalent.
//   The cfg port writes channel_map, calibration_offset and pga_gain; write
//   it only while no request is in flight.
// Timing:
//   A request is registered on acceptance and its response is registered
//   once the output register is free. One request per cycle is sustained
//   while rsp does not stall; the read path (slot select, offset add,
//   one 16x12 multiply, shift and bias add) sits between those two registers.
// Reset and stall:
//   Reset stops the scan, clears the position and all stored samples, and
//   sets gain to 1x. When rsp stalls, the response holds and one further
//   request is taken into the input register; req.ready then drops.
// ----------------------------------------------------------------------------
module adc_channel_scan_sequencer #(
	parameter int NUM_CHANNELS = acss_pkg::NUM_CHANNELS_DEF,
	parameter int SAMPLE_BITS  = acss_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [acss_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [acss_pkg::CFG_DATA_W-1:0]      cfg_data,
	acss_req_if.sink                             req,
	acss_rsp_if.source                           rsp
);
	import acss_pkg::*;

	localparam int LANES = (NUM_CHANNELS < MAP_W) ? NUM_CHANNELS : MAP_W;
	localparam logic [MAP_W-1:0] LANE_MASK = MAP_W'((33'd1 << LANES) - 33'd1);
	localparam int STORE_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
	localparam int SLOTS = 1 << SLOT_W;

	// Configuration and derived scan tables
	logic [MAP_W-1:0]         map_q;
	logic [OFFSET_W-1:0]      offset_q;
	logic [GAIN_W-1:0]        gain_q;
	logic [LEN_W-1:0]         len_q;
	logic [CHAN_W-1:0]        pfx_q [MAP_W];
	logic [MAP_W-1:0]         map_new;
	logic [CHAN_W-1:0]        pfx_new [MAP_W];

	// Scan state and sample store
	logic                     running_q;
	logic [SLOT_W-1:0]        pos_q;
	logic [STORE_BITS-1:0]    store_q [SLOTS];

	// Input stage
	logic                     valid_s1;
	req_type_t                req_type_s1;
	logic [STORE_BITS-1:0]    sample_s1;
	logic [SLOT_W-1:0]        slot_s1;

	// Output register
	logic                     rsp_valid_q;
	logic                     start_q;
	logic [CHAN_W-1:0]        chan_q;
	logic                     empty_q;
	logic signed [RAW_W-1:0]  raw_q;
	logic signed [MV_W-1:0]   mv_q;

	// Stage logic
	logic                     adv;
	logic                     take;
	logic                     scan_empty;
	logic [LEN_W-1:0]         next_wide;
	logic [SLOT_W-1:0]        pos_adv;
	logic [SLOT_W-1:0]        sel_pos;
	logic [CHAN_W-1:0]        sel_chan;
	logic                     start_d;
	logic                     running_d;
	logic [SLOT_W-1:0]        pos_d;
	logic                     store_we;
	logic signed [RAW_W-1:0]  raw_d;
	logic signed [27:0]       prod;
	logic signed [MV_W-1:0]   mv_d;
	logic                     is_read;

	// Handshake: the input register moves on when the output register frees
	assign adv       = !rsp_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || adv;
	assign take      = valid_s1 && adv;

	// Derive usable map and per-channel prefix counts from a map write
	always_comb begin
		map_new = cfg_data[MAP_W-1:0] & LANE_MASK;
		for (int c = 0; c < MAP_W; c++) begin
			pfx_new[c] = CHAN_W'(pop_map(map_new & MAP_W'((33'd1 << c) - 33'd1)));
		end
	end

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q    <= '0;
			offset_q <= '0;
			gain_q   <= GAIN_RESET;
			len_q    <= '0;
			for (int c = 0; c < MAP_W; c++) begin
				pfx_q[c] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CHANNEL_MAP: begin
					map_q <= map_new;
					len_q <= pop_map(map_new);
					for (int c = 0; c < MAP_W; c++) begin
						pfx_q[c] <= pfx_new[c];
					end
				end
				CFG_CAL_OFFSET: offset_q <= cfg_data[OFFSET_W-1:0];
				CFG_PGA_GAIN:   gain_q   <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Capture the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1 <= req.req_type;
			sample_s1   <= req.sample[STORE_BITS-1:0];
			slot_s1     <= req.read_slot;
		end
	end

	// Advance the scan position, wrapping at the scan length
	assign scan_empty = (len_q == '0);
	assign next_wide  = LEN_W'(pos_q) + LEN_W'(1);
	assign pos_adv    = (next_wide >= len_q) ? '0 : next_wide[SLOT_W-1:0];

	// Decode the request into next state and conversion request
	always_comb begin
		running_d = running_q;
		pos_d     = pos_q;
		start_d   = 1'b0;
		store_we  = 1'b0;
		sel_pos   = '0;
		is_read   = 1'b0;
		case (req_type_s1)
			REQ_CONV_DONE: begin
				if (running_q) begin
					store_we = 1'b1;
					pos_d    = pos_adv;
					sel_pos  = pos_adv;
					if (scan_empty) begin
						running_d = 1'b0;
					end else begin
						start_d = 1'b1;
					end
				end
			end
			REQ_START: begin
				if (!scan_empty) begin
					running_d = 1'b1;
					pos_d     = '0;
					start_d   = 1'b1;
				end
			end
			REQ_STOP: begin
				running_d = 1'b0;
				pos_d     = '0;
			end
			REQ_READ: is_read = 1'b1;
			default: ;
		endcase
	end

	// Pick the channel whose prefix count matches the selected position
	always_comb begin
		sel_chan = '0;
		for (int c = 0; c < MAP_W; c++) begin
			if (map_q[c] && pfx_q[c] == sel_pos) begin
				sel_chan = sel_chan | CHAN_W'(c);
			end
		end
	end

	// Apply calibration offset and scale to Q15 millivolts
	always_comb begin
		raw_d = RAW_W'({{(RAW_W-STORE_BITS){1'b0}}, store_q[slot_s1]})
			+ RAW_W'(signed'(offset_q));
		prod  = 28'(raw_d) * 28'(MV_PER_LSB);
		if (gain_q == GAIN_OFF) begin
			mv_d = '0;
		end else begin
			mv_d = (MV_W'(prod) <<< (GAIN_MAX_SHIFT - gain_q)) + gain_bias(gain_q);
		end
	end

	// Update scan state and sample store on each processed request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			pos_q     <= '0;
			for (int s = 0; s < SLOTS; s++) begin
				store_q[s] <= '0;
			end
		end else if (take) begin
			running_q <= running_d;
			pos_q     <= pos_d;
			if (store_we) begin
				store_q[pos_q] <= sample_s1;
			end
		end
	end

	// Register the response
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			start_q <= start_d;
			chan_q  <= start_d ? sel_chan : '0;
			empty_q <= scan_empty;
			raw_q   <= is_read ? raw_d : '0;
			mv_q    <= is_read ? mv_d : '0;
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.start_conversion = start_q;
	assign rsp.next_channel     = chan_q;
	assign rsp.scan_empty       = empty_q;
	assign rsp.raw_value        = raw_q;
	assign rsp.millivolts_q15   = mv_q;

endmodule

// File: hw/rtl/acss_checker.sv
// ----------------------------------------------------------------------------
// ADC scan sequencer checker
// Port-level checks on response consistency and request-to-response timing.
// ----------------------------------------------------------------------------
module acss_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                req_valid,
	input logic                                req_ready,
	input logic                                rsp_valid,
	input logic                                rsp_ready,
	input logic                                start_conversion,
	input logic [acss_pkg::CHAN_W-1:0]         next_channel,
	input logic                                scan_empty,
	input logic signed [acss_pkg::RAW_W-1:0]   raw_value,
	input logic signed [acss_pkg::MV_W-1:0]    millivolts_q15
);
	import acss_pkg::*;

	// A conversion is never requested from an empty scan list
	a_start_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && start_conversion |-> !scan_empty)
		else $error("conversion requested with empty scan list");

	// Idle responses carry no channel
	a_chan_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !start_conversion |-> next_channel == '0)
		else $error("channel set without conversion request");

	// Readout values never come with a conversion request
	a_read_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (raw_value != '0 || millivolts_q15 != '0) |-> !start_conversion)
		else $error("readout value on a conversion response");

	// An accepted request is followed by a response when rsp is ready in the cycle after acceptance
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready ##1 rsp_ready |=> rsp_valid)
		else $error("response missing after accepted request");

endmodule

bind adc_channel_scan_sequencer acss_checker u_acss_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.start_conversion (rsp.start_conversion),
	.next_channel     (rsp.next_channel),
	.scan_empty       (rsp.scan_empty),
	.raw_value        (rsp.raw_value),
	.millivolts_q15   (rsp.millivolts_q15)
);

// File: dv/tb_adc_channel_scan_sequencer.sv
// ----------------------------------------------------------------------------
// ADC channel scan sequencer testbench
// Drives scan, conversion-done, stop and read requests with random gaps and
// response stalls. A scoreboard tracks the scan position and sample store,
// predicts every response and compares it field by field.
// ----------------------------------------------------------------------------
import acss_pkg::*;

typedef struct packed {
	logic                start_conversion;
	logic [CHAN_W-1:0]   next_channel;
	logic                scan_empty;
	logic [RAW_W-1:0]    raw_value;
	logic [MV_W-1:0]     millivolts_q15;
} scan_reply_t;

class scan_scoreboard;
	logic [MAP_W-1:0]    chan_map;
	logic [OFFSET_W-1:0] cal_offset;
	logic [GAIN_W-1:0]   gain;
	logic [CHAN_W-1:0]   position;
	bit                  running;
	logic [SAMPLE_W-1:0] samples [16];
	scan_reply_t         expected_replies [$];
	longint              q15_bias [7];
	int unsigned         kind_count [4];
	int unsigned         replies_checked;
	int unsigned         mismatches;

	function new();
		chan_map = '0;
		cal_offset = '0;
		gain = GAIN_RESET;
		position = '0;
		running = 1'b0;
		foreach (samples[i]) samples[i] = '0;
		foreach (kind_count[i]) kind_count[i] = 0;
		replies_checked = 0;
		mismatches = 0;
		q15_bias = '{-103219200, -34406400, 0, 17203200, 25804800, 30105600, 32256000};
	endfunction

	function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_CHANNEL_MAP: chan_map = data[MAP_W-1:0];
			CFG_CAL_OFFSET:  cal_offset = data[OFFSET_W-1:0];
			CFG_PGA_GAIN:    gain = data[GAIN_W-1:0];
			default: ;
		endcase
	endfunction

	// Find the channel at a given scan position, lowest set bit first
	function logic [CHAN_W-1:0] channel_at(logic [CHAN_W-1:0] p);
		int unsigned k;
		k = 0;
		for (int c = 0; c < MAP_W; c++) begin
			if (chan_map[c]) begin
				if (k == p)
					return CHAN_W'(c);
				k++;
			end
		end
		return '0;
	endfunction

	// Advance the scan state for an accepted request and queue its response
	function void note_request(req_type_t kind, logic [SAMPLE_W-1:0] smp,
			logic [SLOT_W-1:0] slot);
		scan_reply_t      want;
		int unsigned      len;
		int unsigned      nxt;
		logic [RAW_W-1:0] sum;
		longint           mv;
		want = '0;
		len = $countones(chan_map);
		kind_count[kind]++;
		want.scan_empty = (len == 0);
		case (kind)
			REQ_CONV_DONE: begin
				if (running) begin
					samples[position] = smp;
					nxt = position + 1;
					if (nxt >= len)
						nxt = 0;
					position = CHAN_W'(nxt);
					if (len == 0) begin
						running = 1'b0;
					end else begin
						want.start_conversion = 1'b1;
						want.next_channel = channel_at(position);
					end
				end
			end
			REQ_START: begin
				// refuse the start on an empty map
				if (len != 0) begin
					position = '0;
					running = 1'b1;
					want.start_conversion = 1'b1;
					want.next_channel = channel_at('0);
				end
			end
			REQ_STOP: begin
				running = 1'b0;
				position = '0;
			end
			default: begin
				sum = RAW_W'(samples[slot]) + RAW_W'($signed(cal_offset));
				mv = 0;
				if (gain != GAIN_OFF)
					mv = longint'($signed(sum)) * longint'(MV_PER_LSB) *
						(longint'(1) << (GAIN_MAX_SHIFT - gain)) + q15_bias[gain];
				want.raw_value = sum;
				want.millivolts_q15 = MV_W'(mv);
			end
		endcase
		expected_replies.push_back(want);
	endfunction

	function void check_field(string what, logic [MV_W-1:0] want, logic [MV_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %0h got %0h", $time, what, want, got);
		end
	endfunction

	// Compare a response with the oldest pending expectation
	function void check_response(scan_reply_t got);
		scan_reply_t want;
		if (expected_replies.size() == 0) begin
			mismatches++;
			$display("%0t: response with none expected, got %p", $time, got);
			return;
		end
		want = expected_replies.pop_front();
		replies_checked++;
		check_field("start_conversion", MV_W'(want.start_conversion),
			MV_W'(got.start_conversion));
		check_field("next_channel", MV_W'(want.next_channel), MV_W'(got.next_channel));
		check_field("scan_empty", MV_W'(want.scan_empty), MV_W'(got.scan_empty));
		check_field("raw_value", MV_W'(want.raw_value), MV_W'(got.raw_value));
		check_field("millivolts_q15", want.millivolts_q15, got.millivolts_q15);
	endfunction

	function int unsigned outstanding();
		return expected_replies.size();
	endfunction

	function void flag_leftovers();
		if (expected_replies.size() != 0) begin
			mismatches += expected_replies.size();
			$display("%0t: %0d responses never arrived", $time, expected_replies.size());
		end
	endfunction
endclass

module tb_adc_channel_scan_sequencer;

	localparam int HOLD_OFF_CYCLES = 60;
	localparam int RANDOM_PHASES   = 15;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bit idle_on;
	bit hold_off_req;

	scan_scoreboard board;

	acss_req_if req_ch ();
	acss_rsp_if rsp_ch ();

	adc_channel_scan_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Mostly short gaps, a few long ones
	function automatic int unsigned gap_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 8);
		return $urandom_range(12, 40);
	endfunction

	// Offer one request and hold it until accepted
	task automatic send_request(req_type_t kind, logic [SAMPLE_W-1:0] smp,
			logic [SLOT_W-1:0] slot);
		int unsigned gap;
		gap = (idle_on && $urandom_range(0, 99) < 30) ? gap_length() : 0;
		repeat (gap) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.sample <= smp;
		req_ch.read_slot <= slot;
		do
			@(posedge clk);
		while (!req_ch.ready);
		board.note_request(kind, smp, slot);
	endtask

	// Drop valid and wait for every pending response
	task automatic wait_drained();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (board.outstanding() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		board.set_register(idx, data);
	endtask

	// Pick a register setting, favoring the extremes
	task automatic randomize_config();
		int unsigned r;
		logic [MAP_W-1:0]    map;
		logic [OFFSET_W-1:0] offset;
		r = $urandom_range(0, 99);
		if (r < 15)
			map = '1;
		else if (r < 25)
			map = '0;
		else if (r < 45)
			map = MAP_W'(1) << $urandom_range(0, MAP_W - 1);
		else
			map = MAP_W'($urandom());
		r = $urandom_range(0, 99);
		if (r < 15)
			offset = {1'b1, {(OFFSET_W-1){1'b0}}};
		else if (r < 30)
			offset = {1'b0, {(OFFSET_W-1){1'b1}}};
		else
			offset = OFFSET_W'($urandom());
		write_register(CFG_CHANNEL_MAP, CFG_DATA_W'(map));
		write_register(CFG_CAL_OFFSET, CFG_DATA_W'(offset));
		write_register(CFG_PGA_GAIN, CFG_DATA_W'($urandom_range(0, 7)));
	endtask

	// Start a scan, then mostly conversions and reads with some noise
	task automatic random_phase(int unsigned n);
		int unsigned r;
		req_type_t   kind;
		logic [SAMPLE_W-1:0] smp;
		send_request(REQ_START, SAMPLE_W'($urandom()), SLOT_W'($urandom()));
		repeat (n - 1) begin
			r = $urandom_range(0, 99);
			if (r < 55)
				kind = REQ_CONV_DONE;
			else if (r < 85)
				kind = REQ_READ;
			else if (r < 93)
				kind = REQ_START;
			else
				kind = REQ_STOP;
			r = $urandom_range(0, 99);
			if (r < 8)
				smp = '0;
			else if (r < 16)
				smp = '1;
			else
				smp = SAMPLE_W'($urandom());
			send_request(kind, smp, SLOT_W'($urandom()));
		end
	endtask

	// Response ready: random stalls, plus one long hold-off on request
	initial begin
		int unsigned stall;
		rsp_ch.ready = 1'b0;
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				repeat (HOLD_OFF_CYCLES) begin
					@(negedge clk);
					rsp_ch.ready <= 1'b0;
				end
			end else if (idle_on && $urandom_range(0, 99) < 15) begin
				stall = gap_length();
				repeat (stall) begin
					@(negedge clk);
					rsp_ch.ready <= 1'b0;
				end
			end else begin
				@(negedge clk);
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Check every response handshake
	initial begin
		scan_reply_t got;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				got.start_conversion = rsp_ch.start_conversion;
				got.next_channel = rsp_ch.next_channel;
				got.scan_empty = rsp_ch.scan_empty;
				got.raw_value = rsp_ch.raw_value;
				got.millivolts_q15 = rsp_ch.millivolts_q15;
				board.check_response(got);
			end
		end
	end

	initial begin
		#1_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		board = new();
		idle_on = 1'b0;
		hold_off_req = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_CONV_DONE;
		req_ch.sample = '0;
		req_ch.read_slot = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Empty map after reset: refused start, ignored conversion, cleared store
		send_request(REQ_READ, '0, '0);
		send_request(REQ_START, '0, '0);
		send_request(REQ_CONV_DONE, '1, '0);
		send_request(REQ_STOP, '0, '0);
		send_request(REQ_READ, '0, '1);
		wait_drained();

		// Two-channel scan at the edges, largest offset, highest gain
		write_register(CFG_CHANNEL_MAP, 16'h8001);
		write_register(CFG_CAL_OFFSET, 16'h07FF);
		write_register(CFG_PGA_GAIN, 16'd6);
		send_request(REQ_START, '0, '0);
		send_request(REQ_CONV_DONE, '1, '0);
		send_request(REQ_CONV_DONE, '0, '0);
		send_request(REQ_CONV_DONE, 12'hAAA, '0);
		send_request(REQ_START, '0, '0);
		send_request(REQ_CONV_DONE, 12'h555, '0);
		send_request(REQ_READ, '0, 4'd0);
		send_request(REQ_READ, '0, 4'd1);
		send_request(REQ_READ, '1, 4'd15);
		send_request(REQ_STOP, '0, '0);
		send_request(REQ_CONV_DONE, '1, '0);
		wait_drained();

		// Full map, most negative offset, lowest gain
		write_register(CFG_CHANNEL_MAP, 16'hFFFF);
		write_register(CFG_CAL_OFFSET, 16'h0800);
		write_register(CFG_PGA_GAIN, 16'd0);
		send_request(REQ_START, '0, '0);
		send_request(REQ_CONV_DONE, '1, '0);
		send_request(REQ_CONV_DONE, 12'h123, '0);
		send_request(REQ_CONV_DONE, '1, '0);
		send_request(REQ_READ, '0, 4'd1);
		wait_drained();

		// Shorten the scan below the current position, then wrap
		write_register(CFG_CHANNEL_MAP, 16'h0002);
		send_request(REQ_CONV_DONE, 12'h7FF, '0);
		wait_drained();

		// Gain off gives zero voltage
		write_register(CFG_PGA_GAIN, 16'd7);
		send_request(REQ_READ, '0, 4'd3);
		wait_drained();

		// Empty the map while running: store, then stop
		write_register(CFG_CHANNEL_MAP, 16'h0000);
		send_request(REQ_CONV_DONE, 12'h800, '0);
		send_request(REQ_START, '0, '0);
		send_request(REQ_READ, '0, '0);
		wait_drained();

		// Random phases; one runs with a long response hold-off and no gaps
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			randomize_config();
			idle_on = (p % 4 != 0);
			if (p == 2) begin
				idle_on = 1'b0;
				hold_off_req = 1'b1;
			end
			random_phase($urandom_range(50, 75));
			wait_drained();
		end

		board.flag_leftovers();
		$display("Covered %0d conversions, %0d starts, %0d stops, %0d reads",
			board.kind_count[REQ_CONV_DONE], board.kind_count[REQ_START],
			board.kind_count[REQ_STOP], board.kind_count[REQ_READ]);
		$display("over %0d register settings, %0d responses checked",
			RANDOM_PHASES + 5, board.replies_checked);
		if (board.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: adc_channel_scan_sequencer.f
hw/rtl/acss_pkg.sv
hw/rtl/acss_if.sv
hw/rtl/adc_channel_scan_sequencer.sv
hw/rtl/acss_checker.sv
dv/tb_adc_channel_scan_sequencer.sv
